// File: rtl/pbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pbps_pkg;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_CREATE = 3'd1;
  localparam logic [2:0] ACT_SETST  = 3'd2;
  localparam logic [2:0] ACT_SETPR  = 3'd3;
  localparam logic [2:0] ACT_SELECT = 3'd4;

  localparam logic [1:0] ST_UNUSED   = 2'd0;
  localparam logic [1:0] ST_SLEEPING = 2'd1;
  localparam logic [1:0] ST_RUNNABLE = 2'd2;
  localparam logic [1:0] ST_RUNNING  = 2'd3;

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_CREATE = 3'd2;
  localparam logic [2:0] OP_SETST  = 3'd3;
  localparam logic [2:0] OP_SETPR  = 3'd4;
  localparam logic [2:0] OP_NICE   = 3'd5;
  localparam logic [2:0] OP_COMMIT = 3'd6;

  localparam logic [6:0] PRIO_RESET = 7'd60;
  localparam logic [6:0] DP_MAX     = 7'd100;
  localparam logic [3:0] NICE_MID   = 4'd5;
  localparam logic [3:0] NICE_TOP   = 4'd10;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] slot;
    logic [1:0] nst;
    logic [6:0] npr;
    logic [6:0] dprio;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/pbps_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pbps_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [5:0] slot;
  logic [1:0] new_state;
  logic [6:0] new_priority;
  modport source (output valid, action, slot, new_state, new_priority, input ready);
  modport sink (input valid, action, slot, new_state, new_priority, output ready);
endinterface

interface pbps_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [5:0] chosen_slot;
  logic [6:0] chosen_dynamic_priority;
  logic [6:0] prev_priority;
  modport source (output valid, found, chosen_slot, chosen_dynamic_priority, prev_priority,
                  input ready);
  modport sink (input valid, found, chosen_slot, chosen_dynamic_priority, prev_priority,
                output ready);
endinterface
`default_nettype wire

// File: rtl/pbps_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module pbps_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int TB  = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pbps_pkg::cmd_t    cmd,
  input  wire logic [IW-1:0]     win_idx,
  input  wire logic [TB-1:0]     tick_now,
  output logic [6:0]             old_pr,
  input  wire logic              c_in_vld,
  input  wire logic              c_in_have,
  input  wire logic [IW-1:0]     c_in_win,
  input  wire logic [6:0]        c_in_best,
  input  wire logic [TB-1:0]     c_in_disp,
  input  wire logic [TB-1:0]     c_in_ctime,
  output logic                   c_out_vld,
  output logic                   c_out_have,
  output logic [IW-1:0]          c_out_win,
  output logic [6:0]             c_out_best,
  output logic [TB-1:0]          c_out_disp,
  output logic [TB-1:0]          c_out_ctime
);
  import pbps_pkg::*;

  logic [1:0]    st_r;
  logic [6:0]    pr_r;
  logic [TB-1:0] run_r, slp_r, disp_r, ctime_r;
  logic [3:0]    nice_r, nn_r;
  logic          ndone_r;
  logic          hit, take, le;
  logic [TB+3:0] lhs, rhs;
  logic signed [8:0] dp_raw;
  logic [6:0]    dp;

  assign hit = (32'(cmd.slot) == 32'(IDX));
  assign old_pr = (cmd.op == OP_SETPR && hit && st_r != ST_UNUSED) ? pr_r : 7'd0;

  // n*run <= (10-n)*sleep
  assign lhs = (TB+4)'(run_r) * (TB+4)'(nn_r);
  assign rhs = (TB+4)'(slp_r) * (TB+4)'(NICE_TOP - nn_r);
  assign le  = (lhs <= rhs);

  assign dp_raw = $signed({2'b0, pr_r}) + 9'sd5 - $signed({5'b0, nice_r});
  always_comb begin
    if (dp_raw < 0) begin
      dp = 7'd0;
    end else if (dp_raw > $signed({2'b0, DP_MAX})) begin
      dp = DP_MAX;
    end else begin
      dp = dp_raw[6:0];
    end
  end

  always_comb begin
    if (st_r != ST_RUNNABLE) begin
      take = 1'b0;
    end else if (!c_in_have) begin
      take = 1'b1;
    end else if (dp != c_in_best) begin
      take = dp < c_in_best;
    end else if (disp_r != c_in_disp) begin
      take = disp_r < c_in_disp;
    end else begin
      take = ctime_r < c_in_ctime;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_UNUSED;
      pr_r      <= PRIO_RESET;
      run_r     <= '0;
      slp_r     <= '0;
      disp_r    <= '0;
      ctime_r   <= '0;
      nice_r    <= NICE_MID;
      nn_r      <= NICE_TOP;
      ndone_r   <= 1'b1;
      c_out_vld <= 1'b0;
    end else begin
      c_out_vld <= c_in_vld;
      if (!ndone_r) begin
        if (le) begin
          nice_r  <= nn_r;
          ndone_r <= 1'b1;
        end else if (nn_r == 4'd1) begin
          nice_r  <= 4'd0;
          ndone_r <= 1'b1;
        end else begin
          nn_r <= nn_r - 4'd1;
        end
      end
      case (cmd.op)
        OP_TICK: begin
          if (st_r == ST_RUNNING) run_r <= run_r + TB'(1);
          else if (st_r == ST_SLEEPING) slp_r <= slp_r + TB'(1);
        end
        OP_CREATE: begin
          if (hit && st_r == ST_UNUSED) begin
            st_r    <= ST_RUNNABLE;
            pr_r    <= cmd.dprio;
            run_r   <= '0;
            slp_r   <= '0;
            disp_r  <= '0;
            ctime_r <= tick_now;
          end
        end
        OP_SETST: begin
          if (hit) st_r <= cmd.nst;
        end
        OP_SETPR: begin
          if (hit && st_r != ST_UNUSED) begin
            pr_r  <= cmd.npr;
            run_r <= '0;
          end
        end
        OP_NICE: begin
          if (run_r == '0 && slp_r == '0) begin
            nice_r  <= NICE_MID;
            ndone_r <= 1'b1;
          end else begin
            nn_r    <= NICE_TOP;
            ndone_r <= 1'b0;
          end
        end
        OP_COMMIT: begin
          if (win_idx == IW'(IDX)) begin
            run_r  <= '0;
            slp_r  <= '0;
            disp_r <= disp_r + TB'(1);
            st_r   <= ST_RUNNING;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // hand the best request so far to the next cell
  always_ff @(posedge clk) begin
    if (take) begin
      c_out_have  <= 1'b1;
      c_out_win   <= IW'(IDX);
      c_out_best  <= dp;
      c_out_disp  <= disp_r;
      c_out_ctime <= ctime_r;
    end else begin
      c_out_have  <= c_in_have;
      c_out_win   <= c_in_win;
      c_out_best  <= c_in_best;
      c_out_disp  <= c_in_disp;
      c_out_ctime <= c_in_ctime;
    end
  end

endmodule
`default_nettype wire

// File: rtl/priority_based_process_selector.sv
// Task slot selector with dynamic niceness.
// in_ch carries one request per handshake (valid and ready both high):
// action, slot, new_state, new_priority. out_ch returns exactly one result
// per request: found, chosen_slot, chosen_dynamic_priority, prev_priority.
// cfg_we/cfg_wdata write the default priority given to created slots.
// Each slot lives in one cell of a chain. Tick, create, set state and set
// priority are carried out in the execute state, which loads the result.
// Select decodes, then runs the per-cell niceness search (one trial
// quotient per cycle) and lets the best candidate walk the chain one cell
// per cycle; the last step also commits the winner and loads the result.
// One request is in flight at a time; the next one is accepted at the
// earliest in the cycle in which the previous result is taken.
// Reset (rst_n low, synchronous) marks every slot unused with priority 60,
// clears all counters and sets the default priority to 60.
// A stalled receiver holds the result register; no new request is taken
// until that register is free or freed in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module priority_based_process_selector #(
  parameter int SLOTS     = 64,
  parameter int TICK_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  pbps_in_if.sink         in_ch,
  pbps_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata
);
  import pbps_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TB = TICK_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_NICE = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;

  logic [2:0]    state_r, state_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [6:0]    dprio_r;
  logic [TB-1:0] tick_r;
  logic [2:0]    act_r;
  logic [5:0]    slot_r;
  logic [1:0]    nst_r;
  logic [6:0]    npr_r;
  logic          inj;
  cmd_t          cmd;
  logic [IW-1:0] win_idx;

  logic          out_valid_r, out_found_r;
  logic [5:0]    out_slot_r;
  logic [6:0]    out_dp_r, out_old_r;

  logic              c_vld  [SLOTS+1];
  logic              c_have [SLOTS+1];
  logic [IW-1:0]     c_win  [SLOTS+1];
  logic [6:0]        c_best [SLOTS+1];
  logic [TB-1:0]     c_disp [SLOTS+1];
  logic [TB-1:0]     c_ctime[SLOTS+1];
  logic [6:0]        old_pr [SLOTS];
  logic [6:0]        old_any;

  logic accept, last_vld;
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign last_vld    = c_vld[SLOTS];

  assign c_vld[0]   = inj;
  assign c_have[0]  = 1'b0;
  assign c_win[0]   = '0;
  assign c_best[0]  = '0;
  assign c_disp[0]  = '0;
  assign c_ctime[0] = '0;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      pbps_cell #(.IDX(g), .IW(IW), .TB(TB)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .win_idx    (win_idx),
        .tick_now   (tick_r),
        .old_pr     (old_pr[g]),
        .c_in_vld   (c_vld[g]),
        .c_in_have  (c_have[g]),
        .c_in_win   (c_win[g]),
        .c_in_best  (c_best[g]),
        .c_in_disp  (c_disp[g]),
        .c_in_ctime (c_ctime[g]),
        .c_out_vld  (c_vld[g+1]),
        .c_out_have (c_have[g+1]),
        .c_out_win  (c_win[g+1]),
        .c_out_best (c_best[g+1]),
        .c_out_disp (c_disp[g+1]),
        .c_out_ctime(c_ctime[g+1])
      );
    end
  endgenerate

  always_comb begin
    old_any = '0;
    for (int i = 0; i < SLOTS; i++) begin
      old_any = old_any | old_pr[i];
    end
  end

  assign win_idx = c_win[SLOTS];

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    inj        = 1'b0;
    cmd.op     = OP_NONE;
    cmd.slot   = slot_r;
    cmd.nst    = nst_r;
    cmd.npr    = npr_r;
    cmd.dprio  = dprio_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (act_r)
          ACT_TICK:   cmd.op = OP_TICK;
          ACT_CREATE: cmd.op = OP_CREATE;
          ACT_SETST:  cmd.op = OP_SETST;
          ACT_SETPR:  cmd.op = OP_SETPR;
          ACT_SELECT: begin
            cmd.op    = OP_NICE;
            cnt_nxt   = '0;
            state_nxt = S_NICE;
          end
          default: cmd.op = OP_NONE;
        endcase
      end
      S_NICE: begin
        cnt_nxt = cnt_r + 4'd1;
        // inject once the last trial has landed in every cell
        if (cnt_r == NICE_TOP) begin
          inj       = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_vld) begin
          if (c_have[SLOTS]) cmd.op = OP_COMMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      dprio_r     <= PRIO_RESET;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) dprio_r <= cfg_wdata;
      if (cmd.op == OP_TICK) tick_r <= tick_r + TB'(1);
      if ((state_r == S_EXEC && act_r != ACT_SELECT) || (state_r == S_SCAN && last_vld)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_ch.action;
      slot_r <= in_ch.slot;
      nst_r  <= in_ch.new_state;
      npr_r  <= in_ch.new_priority;
    end
    if (state_r == S_EXEC && act_r != ACT_SELECT) begin
      out_found_r <= 1'b0;
      out_slot_r  <= '0;
      out_dp_r    <= '0;
      out_old_r   <= old_any;
    end else if (state_r == S_SCAN && last_vld) begin
      out_found_r <= c_have[SLOTS];
      out_slot_r  <= c_have[SLOTS] ? 6'(32'(c_win[SLOTS]) & 32'd63) : 6'd0;
      out_dp_r    <= c_have[SLOTS] ? c_best[SLOTS] : 7'd0;
      out_old_r   <= '0;
    end
  end

  assign out_ch.valid                   = out_valid_r;
  assign out_ch.found                   = out_found_r;
  assign out_ch.chosen_slot             = out_slot_r;
  assign out_ch.chosen_dynamic_priority = out_dp_r;
  assign out_ch.prev_priority           = out_old_r;

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE)
    else $error("request taken while busy");
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    last_vld |-> state_r == S_SCAN)
    else $error("candidate left chain outside scan");
  a_dp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_dp_r <= DP_MAX)
    else $error("dynamic priority out of range");
  a_found_only_select: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && act_r != ACT_SELECT) |=> !out_found_r)
    else $error("found set by non-select request");
`endif

endmodule
`default_nettype wire
